[hw/rtl/fci_pkg.sv]
// Shared types and constants for the fan curve interpolator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package fci_pkg;

  localparam int POINT_COUNT = 7;
  localparam int LAST_POINT  = POINT_COUNT - 1;
  localparam int SEG_W       = $clog2(POINT_COUNT);

  localparam int TEMP_W      = 8;
  localparam int DUTY_W      = 10;
  localparam int PROD_W      = DUTY_W + TEMP_W;
  localparam int DIV_STAGES  = DUTY_W;
  localparam int QUEUE_DEPTH = 2;

  localparam int BP_W        = 56;
  localparam int DL_W        = 40;
  localparam int DH_W        = 30;
  localparam int CFG_W       = BP_W;
  localparam int DL_POINTS   = 4;

  localparam logic [BP_W-1:0] BP_RESET = 56'h322D231E1B160A;
  localparam logic [DL_W-1:0] DL_RESET = 40'h8010000000;
  localparam logic [DH_W-1:0] DH_RESET = 30'h3FFFFF00;

  typedef enum logic [1:0] {
    CFG_TEMP_BP   = 2'd0,
    CFG_DUTY_LOW  = 2'd1,
    CFG_DUTY_HIGH = 2'd2
  } cfg_idx_t;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [DUTY_W-1:0]        duty_t;
  typedef logic [TEMP_W-1:0]        den_t;
  typedef logic [PROD_W-1:0]        prod_t;

  // One classified transaction, as queued between front and back.
  typedef struct packed {
    duty_t base;
    logic  neg;
    prod_t prod;
    den_t  den;
    logic  fault;
  } job_t;

endpackage

[hw/rtl/fci_front.sv]
// Front end: accepts temperatures, finds the curve segment and forms the product.
// Depends on fci_pkg.
`timescale 1ns / 1ps

module fci_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  fci_pkg::temp_t in_temperature,
  input  fci_pkg::temp_t bp_temp [fci_pkg::POINT_COUNT],
  input  fci_pkg::duty_t bp_duty [fci_pkg::POINT_COUNT],
  input  logic           queue_full,
  output logic           busy,
  output logic           push,
  output fci_pkg::job_t  push_data
);
  import fci_pkg::*;

  typedef struct packed {
    duty_t base;
    logic  neg;
    duty_t mag;
    den_t  dt;
    den_t  den;
    logic  fault;
  } cls_t;

  logic             f1_vld_r, f1_vld_nxt;
  cls_t             f1_r, f1_nxt;
  logic             take;
  logic             below, above, found;
  logic [SEG_W-1:0] idx;
  temp_t            t0, t1;
  duty_t            d0, d1;
  logic signed [TEMP_W:0] dt_w, den_w;
  logic signed [DUTY_W:0] dd_w, dd_abs;

  assign busy = f1_vld_r & queue_full;
  assign take = start & ~busy;
  assign push = f1_vld_r & ~queue_full;

  // Classify against the breakpoints; first matching segment wins.
  always_comb begin
    below = in_temperature < bp_temp[0];
    above = in_temperature >= bp_temp[LAST_POINT];
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < LAST_POINT; i++) begin
      if (!found && in_temperature >= bp_temp[i] && in_temperature < bp_temp[i+1]) begin
        found = 1'b1;
        idx   = SEG_W'(i);
      end
    end
    t0     = bp_temp[idx];
    t1     = bp_temp[SEG_W'(idx + 1'b1)];
    d0     = bp_duty[idx];
    d1     = bp_duty[SEG_W'(idx + 1'b1)];
    dt_w   = {in_temperature[TEMP_W-1], in_temperature} - {t0[TEMP_W-1], t0};
    den_w  = {t1[TEMP_W-1], t1} - {t0[TEMP_W-1], t0};
    dd_w   = $signed({1'b0, d1}) - $signed({1'b0, d0});
    dd_abs = dd_w[DUTY_W] ? -dd_w : dd_w;

    f1_nxt.base  = '0;
    f1_nxt.neg   = 1'b0;
    f1_nxt.mag   = '0;
    f1_nxt.dt    = '0;
    f1_nxt.den   = den_t'(1);
    f1_nxt.fault = 1'b0;
    if (below) begin
      f1_nxt.base = bp_duty[0];
    end else if (above) begin
      f1_nxt.base = bp_duty[LAST_POINT];
    end else if (found) begin
      f1_nxt.base = d0;
      f1_nxt.neg  = dd_w[DUTY_W];
      f1_nxt.mag  = dd_abs[DUTY_W-1:0];
      f1_nxt.dt   = dt_w[TEMP_W-1:0];
      f1_nxt.den  = den_w[TEMP_W-1:0];
    end else begin
      f1_nxt.fault = 1'b1;
    end
  end

  always_comb begin
    f1_vld_nxt = f1_vld_r;
    if (!busy) begin
      f1_vld_nxt = start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= f1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f1_r <= f1_nxt;
    end
  end

  // Product is registered by the queue entry.
  always_comb begin
    push_data.base  = f1_r.base;
    push_data.neg   = f1_r.neg;
    push_data.prod  = PROD_W'(f1_r.mag) * PROD_W'(f1_r.dt);
    push_data.den   = f1_r.den;
    push_data.fault = f1_r.fault;
  end

endmodule

[hw/rtl/fci_queue.sv]
// Short transaction queue between the front end and the divider back end.
// Depends on fci_pkg.
`timescale 1ns / 1ps

module fci_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fci_pkg::job_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output fci_pkg::job_t head_data
);
  import fci_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/fci_back.sv]
// Back end: pipelined restoring divider, one quotient bit per stage, then offset add.
// Depends on fci_pkg.
`timescale 1ns / 1ps

module fci_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  fci_pkg::job_t head_data,
  output logic          pop,
  output logic          out_valid,
  output fci_pkg::duty_t out_duty,
  output logic          out_table_fault
);
  import fci_pkg::*;

  typedef struct packed {
    den_t  rem;
    duty_t lo;
    duty_t q;
    den_t  den;
    duty_t base;
    logic  neg;
    logic  fault;
  } div_t;

  div_t                  st_r [DIV_STAGES];
  div_t                  st_in [DIV_STAGES];
  div_t                  st_nxt [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_r, vld_nxt;
  logic                  out_valid_r;
  duty_t                 out_duty_r, duty_nxt;
  logic                  out_fault_r;

  function automatic div_t div_step(div_t s);
    logic [TEMP_W:0] trial;
    logic            ge;
    div_t            r;
    trial = {s.rem, s.lo[DUTY_W-1]};
    ge    = trial >= {1'b0, s.den};
    r     = s;
    r.rem = ge ? den_t'(trial - {1'b0, s.den}) : trial[TEMP_W-1:0];
    r.lo  = {s.lo[DUTY_W-2:0], 1'b0};
    r.q   = {s.q[DUTY_W-2:0], ge};
    return r;
  endfunction

  // Never stall: drain the queue whenever it holds a transaction.
  assign pop = head_valid;

  always_comb begin
    // Quotient fits in DUTY_W bits, so the top bits already sit below den.
    st_in[0].rem   = head_data.prod[PROD_W-1:DUTY_W];
    st_in[0].lo    = head_data.prod[DUTY_W-1:0];
    st_in[0].q     = '0;
    st_in[0].den   = head_data.den;
    st_in[0].base  = head_data.base;
    st_in[0].neg   = head_data.neg;
    st_in[0].fault = head_data.fault;
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_in[k] = st_r[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      st_nxt[k] = div_step(st_in[k]);
    end
    vld_nxt = {vld_r[DIV_STAGES-2:0], head_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      st_r[k] <= st_nxt[k];
    end
    out_duty_r  <= duty_nxt;
    out_fault_r <= st_r[DIV_STAGES-1].fault;
  end

  assign duty_nxt = st_r[DIV_STAGES-1].neg ?
                    duty_t'(st_r[DIV_STAGES-1].base - st_r[DIV_STAGES-1].q) :
                    duty_t'(st_r[DIV_STAGES-1].base + st_r[DIV_STAGES-1].q);

  assign out_valid       = out_valid_r;
  assign out_duty        = out_duty_r;
  assign out_table_fault = out_fault_r;

endmodule

[hw/rtl/fan_curve_interpolator.sv]
// Top level of the fan curve interpolator: configuration registers and block wiring.
// Depends on fci_pkg, fci_front, fci_queue and fci_back.
`timescale 1ns / 1ps

// Fan curve interpolator: maps a signed temperature to a 10-bit PWM duty along
// a piecewise-linear curve of up to seven breakpoints.
//
// Input: a transaction is taken on a rising edge with start high and busy low;
// in_temperature is sampled there. Output: out_valid strobes for one cycle with
// out_duty and out_table_fault; the receiver cannot hold results off.
// Configuration: cfg_we writes cfg_data into register cfg_index at once
// (0 breakpoint temperatures, 1 duties 0..3, 2 duties 4..6); other indexes are
// dropped. Write only while no transaction is in flight.
//
// A transaction passes through one classify stage, one multiply stage into the
// queue, ten divider stages of one quotient bit each, and the output register
// on its way to the output strobe. Throughput is one transaction per cycle
// while busy is low; the divider pipeline sets the latency. Because the back end never
// stalls, the queue stays nearly empty and busy stays low in practice.
//
// Reset restores the default curve and flushes all in-flight transactions.
// A temperature inside the curve span that matches no segment (breakpoints
// not ascending) gives duty 0 with table_fault set.

module fan_curve_interpolator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [7:0]          in_temperature,
  output logic                       out_valid,
  output logic [9:0]                 out_duty,
  output logic                       out_table_fault,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [fci_pkg::CFG_W-1:0]  cfg_data
);
  import fci_pkg::*;

  logic [BP_W-1:0] bp_r;
  logic [DL_W-1:0] dl_r;
  logic [DH_W-1:0] dh_r;
  temp_t           bp_temp [POINT_COUNT];
  duty_t           bp_duty [POINT_COUNT];
  logic            queue_full, push, head_valid, pop;
  job_t            push_data, head_data;

  // Register file: decode index, mask data to register width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r <= BP_RESET;
      dl_r <= DL_RESET;
      dh_r <= DH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMP_BP:   bp_r <= cfg_data[BP_W-1:0];
        CFG_DUTY_LOW:  dl_r <= cfg_data[DL_W-1:0];
        CFG_DUTY_HIGH: dh_r <= cfg_data[DH_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the curve; points past POINT_COUNT are ignored.
  for (genvar k = 0; k < POINT_COUNT; k++) begin : g_pt
    assign bp_temp[k] = temp_t'(bp_r[TEMP_W*k +: TEMP_W]);
    if (k < DL_POINTS) begin : g_lo
      assign bp_duty[k] = dl_r[DUTY_W*k +: DUTY_W];
    end else begin : g_hi
      assign bp_duty[k] = dh_r[DUTY_W*(k-DL_POINTS) +: DUTY_W];
    end
  end

  fci_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_temperature (in_temperature),
    .bp_temp        (bp_temp),
    .bp_duty        (bp_duty),
    .queue_full     (queue_full),
    .busy           (busy),
    .push           (push),
    .push_data      (push_data)
  );

  fci_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  fci_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_data       (head_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_duty        (out_duty),
    .out_table_fault (out_table_fault)
  );

endmodule
